// ===== sv/ctd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer package
// Field widths, time constants, action codes and the stage beat type.
// ----------------------------------------------------------------------------
package ctd_pkg;

    localparam int ACTION_W = 3;
    localparam int PRESET_W = 7;
    localparam int DELTA_W  = 14;
    localparam int NOW_W    = 32;
    localparam int MS_W     = 23;
    localparam int STEP_W   = 10;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int QMIN_W   = 7;
    localparam int TSEC_W   = 13;
    localparam int ADJ_W    = 24;
    localparam int PROD_W   = 48;

    localparam logic [STEP_W-1:0]   STEP_RESET     = 10'd100;
    localparam logic [PRESET_W-1:0] MAX_PRESET_MIN = 7'd99;
    localparam logic [MS_W-1:0]     CAP_MS         = 23'd5940000;
    localparam logic [MS_W-1:0]     MS_PER_MIN     = 23'd60000;
    localparam logic [ADJ_W-1:0]    MS_PER_SEC     = 24'd1000;
    localparam logic [QMIN_W-1:0]   MIN_PER_HOUR   = 7'd60;
    localparam logic [TSEC_W-1:0]   SEC_PER_MIN    = 13'd60;

    // Exact reciprocals for operands below 2**23.
    localparam logic [PROD_W-1:0] RECIP_MIN       = 48'd9162597;
    localparam int                RECIP_MIN_SHIFT = 39;
    localparam logic [PROD_W-1:0] RECIP_SEC       = 48'd8589935;
    localparam int                RECIP_SEC_SHIFT = 33;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK   = 3'd0,
        ACT_PRESET = 3'd1,
        ACT_ADJUST = 3'd2,
        ACT_TOGGLE = 3'd3,
        ACT_RESET  = 3'd4
    } t_action;

    typedef struct packed {
        logic [MS_W-1:0] left_ms;
        logic            is_running;
        logic            expired;
    } t_beat;

endpackage

// ===== sv/ctd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer channels
// Valid/ready interfaces for the action beats and the result beats.
// ----------------------------------------------------------------------------
interface ctd_in_if;
    import ctd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [PRESET_W-1:0]        preset_minutes;
    logic signed [DELTA_W-1:0]  delta_seconds;
    logic [NOW_W-1:0]           now_ms;

    modport source (output valid, action, preset_minutes, delta_seconds, now_ms,
                    input ready);
    modport sink (input valid, action, preset_minutes, delta_seconds, now_ms,
                  output ready);
endinterface

interface ctd_out_if;
    import ctd_pkg::*;

    logic               valid;
    logic               ready;
    logic [MS_W-1:0]    remaining_ms;
    logic               is_running;
    logic               expired;
    logic               hours;
    logic [MIN_W-1:0]   minutes;
    logic [SEC_W-1:0]   seconds;

    modport source (output valid, remaining_ms, is_running, expired, hours, minutes,
                    seconds, input ready);
    modport sink (input valid, remaining_ms, is_running, expired, hours, minutes,
                  seconds, output ready);
endinterface

// ===== sv/ctd_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer state update
// Applies one action beat per cycle, while the display split is ready, to the
// timer state and registers the new remaining time for the display split.
// ----------------------------------------------------------------------------
module ctd_state (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ctd_pkg::STEP_W-1:0]   i_cfg_wdata,
    ctd_in_if.sink                       i_in,
    output logic                         o_valid,
    input  logic                         i_ready,
    output ctd_pkg::t_beat               o_beat
);
    import ctd_pkg::*;

    logic [STEP_W-1:0] r_step_ms;
    logic              r_run;
    logic [MS_W-1:0]   r_total;
    logic [MS_W-1:0]   r_left;
    logic [NOW_W-1:0]  r_last;
    logic              r_valid;
    t_beat             r_beat;

    logic              n_run;
    logic [MS_W-1:0]   n_total;
    logic [MS_W-1:0]   n_left;
    logic [NOW_W-1:0]  n_last;
    logic              n_expired;

    logic              w_accept;
    logic [STEP_W-1:0] w_step;
    logic [NOW_W-1:0]  w_elapsed;
    logic [PRESET_W-1:0] w_preset;
    logic              w_pos;
    logic [DELTA_W-1:0] w_abs;
    logic [ADJ_W-1:0]  w_amt;
    logic [ADJ_W-1:0]  w_sum;
    logic [MS_W-1:0]   w_reload;

    assign i_in.ready = !r_valid || i_ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_step    = (r_step_ms == '0) ? STEP_W'(1) : r_step_ms;
    assign w_elapsed = i_in.now_ms - r_last;
    assign w_preset  = (i_in.preset_minutes > MAX_PRESET_MIN) ? MAX_PRESET_MIN
                                                              : i_in.preset_minutes;
    assign w_pos     = i_in.delta_seconds > 14'sd0;
    assign w_abs     = w_pos ? DELTA_W'(i_in.delta_seconds)
                             : DELTA_W'(-i_in.delta_seconds);
    assign w_amt     = ADJ_W'(w_abs) * MS_PER_SEC;
    assign w_sum     = ADJ_W'(r_left) + w_amt;
    assign w_reload  = (r_left == '0) ? r_total : r_left;

    always_comb begin
        n_run     = r_run;
        n_total   = r_total;
        n_left    = r_left;
        n_last    = r_last;
        n_expired = 1'b0;
        unique case (i_in.action)
            ACT_TICK: begin
                if (r_run && (w_elapsed >= NOW_W'(w_step))) begin
                    n_last = i_in.now_ms;
                    if (r_left > MS_W'(w_step)) begin
                        n_left = r_left - MS_W'(w_step);
                    end else begin
                        n_left    = '0;
                        n_run     = 1'b0;
                        n_expired = 1'b1;
                    end
                end
            end
            ACT_PRESET: begin
                n_total = MS_W'(w_preset) * MS_PER_MIN;
                n_left  = MS_W'(w_preset) * MS_PER_MIN;
                n_run   = 1'b0;
                n_last  = '0;
            end
            ACT_ADJUST: begin
                if (w_pos) begin
                    n_left = (w_sum > ADJ_W'(CAP_MS)) ? CAP_MS : MS_W'(w_sum);
                    if (r_total == '0) begin
                        n_total = n_left;
                    end
                end else begin
                    n_left = (ADJ_W'(r_left) > w_amt) ? MS_W'(ADJ_W'(r_left) - w_amt) : '0;
                end
                n_last = '0;
            end
            ACT_TOGGLE: begin
                if (r_run) begin
                    n_run = 1'b0;
                end else begin
                    n_left = w_reload;
                    if (w_reload != '0) begin
                        n_run  = 1'b1;
                        n_last = i_in.now_ms;
                    end
                end
            end
            ACT_RESET: begin
                n_run  = 1'b0;
                n_left = r_total;
                n_last = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_ms <= STEP_RESET;
            r_run     <= 1'b0;
            r_total   <= '0;
            r_left    <= '0;
            r_last    <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_step_ms <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_run   <= n_run;
                r_total <= n_total;
                r_left  <= n_left;
                r_last  <= n_last;
            end
            if (i_in.ready) begin
                r_valid <= i_in.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_beat.left_ms    <= n_left;
            r_beat.is_running <= n_run;
            r_beat.expired    <= n_expired;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== sv/ctd_split.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer display split
// Two-stage pipeline that breaks the remaining milliseconds into hours,
// minutes and seconds using constant reciprocals.
// ----------------------------------------------------------------------------
module ctd_split (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ctd_pkg::t_beat  i_beat,
    ctd_out_if.source       o_out
);
    import ctd_pkg::*;

    logic               r2_valid;
    t_beat              r2_beat;
    logic [QMIN_W-1:0]  r2_qmin;
    logic [TSEC_W-1:0]  r2_tsec;

    logic               r3_valid;
    t_beat              r3_beat;
    logic               r3_hours;
    logic [MIN_W-1:0]   r3_minutes;
    logic [SEC_W-1:0]   r3_seconds;

    logic               w_rdy3;
    logic               w_rdy2;
    logic [PROD_W-1:0]  w_pmin;
    logic [PROD_W-1:0]  w_psec;
    logic               w_hours;
    logic [QMIN_W-1:0]  w_min;
    logic [TSEC_W-1:0]  w_sec;

    assign w_rdy3  = !r3_valid || o_out.ready;
    assign w_rdy2  = !r2_valid || w_rdy3;
    assign o_ready = w_rdy2;

    assign w_pmin = PROD_W'(i_beat.left_ms) * RECIP_MIN;
    assign w_psec = PROD_W'(i_beat.left_ms) * RECIP_SEC;

    assign w_hours = r2_qmin >= MIN_PER_HOUR;
    assign w_min   = w_hours ? (r2_qmin - MIN_PER_HOUR) : r2_qmin;
    assign w_sec   = r2_tsec - TSEC_W'(r2_qmin) * SEC_PER_MIN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (w_rdy2) begin
                r2_valid <= i_valid;
            end
            if (w_rdy3) begin
                r3_valid <= r2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && i_valid) begin
            r2_beat <= i_beat;
            r2_qmin <= QMIN_W'(w_pmin >> RECIP_MIN_SHIFT);
            r2_tsec <= TSEC_W'(w_psec >> RECIP_SEC_SHIFT);
        end
        if (w_rdy3 && r2_valid) begin
            r3_beat    <= r2_beat;
            r3_hours   <= w_hours;
            r3_minutes <= MIN_W'(w_min);
            r3_seconds <= SEC_W'(w_sec);
        end
    end

    assign o_out.valid        = r3_valid;
    assign o_out.remaining_ms = r3_beat.left_ms;
    assign o_out.is_running   = r3_beat.is_running;
    assign o_out.expired      = r3_beat.expired;
    assign o_out.hours        = r3_hours;
    assign o_out.minutes      = r3_minutes;
    assign o_out.seconds      = r3_seconds;

endmodule

// ===== sv/countdown_timer_with_presets_core.sv =====
`timescale 1ns / 1ps
// Path: an accepted action beat is registered in the timer state and in both
// split stages before its result beat appears. Throughput: one beat per cycle
// while the output is ready, with the two-stage display split behind the state.
// Reset: synchronous active low; the timer stops, stored times clear to zero,
// the step interval returns to 100 ms and the pipeline empties.
// ----------------------------------------------------------------------------
// Countdown timer with presets
// Event-driven countdown timer with preset loads, signed adjusts, start/stop
// and reset, giving the remaining time and its hours/minutes/seconds split.
// ----------------------------------------------------------------------------
module countdown_timer_with_presets_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ctd_pkg::STEP_W-1:0]   i_cfg_wdata,
    ctd_in_if.sink                       i_in,
    ctd_out_if.source                    o_out
);
    import ctd_pkg::*;

    logic  w_valid;
    logic  w_ready;
    t_beat w_beat;

    ctd_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .o_valid     (w_valid),
        .i_ready     (w_ready),
        .o_beat      (w_beat)
    );

    ctd_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .o_ready (w_ready),
        .i_beat  (w_beat),
        .o_out   (o_out)
    );

endmodule
